FILE: hw/rtl/xcfr_pkg.sv
// Package for the XOR-checked frame receiver: byte type, frame constants,
// result status codes and sequencer states. No dependencies.
package xcfr_pkg;

    typedef logic [7:0] byte_t;

    localparam int    DEF_BUFFER_BYTES = 64;
    localparam byte_t START_MARK       = 8'hFF;
    localparam byte_t CMD_MIN          = 8'hF0;
    localparam int    FRAME_OVERHEAD   = 4;
    localparam int    HEADER_BYTES     = 3;
    localparam int    MAX_DATA         = 60;
    localparam int    TDATA_W          = 32;

    typedef enum logic [1:0] {
        STAT_DATA  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_ERROR = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALIGN_RD,
        ST_ALIGN,
        ST_CMD,
        ST_LEN,
        ST_SUM,
        ST_RESULT,
        ST_EMIT,
        ST_DROP
    } state_t;

endpackage

FILE: hw/rtl/xcfr_store.sv
// Byte store of the frame receiver: one write port, one read port with
// registered read data. Depends on xcfr_pkg.
module xcfr_store #(
    parameter int DEPTH = xcfr_pkg::DEF_BUFFER_BYTES,
    parameter int PTR_W = $clog2(xcfr_pkg::DEF_BUFFER_BYTES)
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [PTR_W-1:0]   wr_addr,
    input  xcfr_pkg::byte_t    wr_data,
    input  logic               rd_en,
    input  logic [PTR_W-1:0]   rd_addr,
    output xcfr_pkg::byte_t    rd_data
);
    import xcfr_pkg::*;

    byte_t mem [DEPTH];
    byte_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/xor_checked_frame_receiver.sv
// Sequence: one byte is written in the accepting cycle; the locate pass then runs
// ALIGN_RD and ALIGN, dropping bytes before a start byte, then CMD and LEN, and SUM when a
// frame is complete, then one result per cycle unless m_tready stalls, then DROP.
// Input: s_tready is low from acceptance until the pass ends, so no new byte is taken
// during a pass; output stalls lengthen the pass, and the single read port of the
// store paces it.
// Reset: synchronous, active low; empties the store (contents are not cleared).
module xor_checked_frame_receiver #(
    parameter int BUFFER_BYTES = xcfr_pkg::DEF_BUFFER_BYTES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [7:0] rx_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [xcfr_pkg::TDATA_W-1:0]   m_tdata,  // [7:0] command, [13:8] data_length,
                                                     // [19:14] data_index, [27:20] data_byte
    output logic [1:0]                     m_tuser,  // [1:0] status
    output logic                           m_tlast
);
    import xcfr_pkg::*;

    localparam int PTR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam int CMP_W = (CNT_W > 9) ? CNT_W + 1 : 10;

    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - PTR_W){1'b0}}, base} + {1'b0, off};
        if (sum >= BUFFER_BYTES[CNT_W:0]) begin
            sum = sum - BUFFER_BYTES[CNT_W:0];
        end
        return sum[PTR_W-1:0];
    endfunction

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   off_reg, off_next;
    byte_t              cmd_reg, cmd_next;
    logic [5:0]         len_reg, len_next;
    byte_t              xor_reg, xor_next;

    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    byte_t              m_cmd_reg, m_cmd_next;
    logic [5:0]         m_len_reg, m_len_next;
    logic [5:0]         m_idx_reg, m_idx_next;
    byte_t              m_byte_reg, m_byte_next;
    logic               m_last_reg, m_last_next;

    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic               rd_en;
    logic [CNT_W-1:0]   rd_off;
    byte_t              rd_data;

    logic               accept;
    logic               full;
    logic               out_free;
    logic [CMP_W-1:0]   fill_ext;
    logic [CMP_W-1:0]   off_ext;
    logic [CMP_W-1:0]   len_ext;
    logic [CMP_W-1:0]   need_ext;
    logic [CMP_W-1:0]   drop_ext;
    logic [CMP_W-1:0]   idx_ext;
    logic               sum_done;
    logic               emit_last;
    byte_t              xor_after;

    xcfr_store #(
        .DEPTH (BUFFER_BYTES),
        .PTR_W (PTR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (ptr_add(head_reg, rd_off)),
        .rd_data (rd_data)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign full      = (fill_reg == BUFFER_BYTES[CNT_W-1:0]);
    assign out_free  = !m_valid_reg || m_tready;
    assign fill_ext  = CMP_W'(fill_reg);
    assign off_ext   = CMP_W'(off_reg);
    assign len_ext   = CMP_W'(len_reg);
    assign need_ext  = CMP_W'(rd_data) + CMP_W'(FRAME_OVERHEAD);
    assign drop_ext  = len_ext + CMP_W'(FRAME_OVERHEAD);
    assign idx_ext   = off_ext - CMP_W'(HEADER_BYTES);
    assign sum_done  = (off_ext == len_ext + CMP_W'(HEADER_BYTES));
    assign emit_last = (off_ext + CMP_W'(1) == len_ext + CMP_W'(HEADER_BYTES));
    assign xor_after = xor_reg ^ rd_data;
    assign wr_addr   = full ? head_reg : ptr_add(head_reg, fill_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_ALIGN_RD;
                end
            end
            ST_ALIGN_RD: begin
                state_next = ST_ALIGN;
            end
            ST_ALIGN: begin
                if (fill_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (rd_data != START_MARK) begin
                    state_next = ST_ALIGN;
                end else if (fill_ext < CMP_W'(HEADER_BYTES)) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_CMD;
                end
            end
            ST_CMD: begin
                state_next = (rd_data < CMD_MIN) ? ST_IDLE : ST_LEN;
            end
            ST_LEN: begin
                if (rd_data > byte_t'(MAX_DATA) || fill_ext < need_ext) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (sum_done) begin
                    if (xor_after != '0 || len_reg == '0) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_DROP;
                end
            end
            ST_EMIT: begin
                if (out_free && emit_last) begin
                    state_next = ST_DROP;
                end
            end
            ST_DROP: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        head_next     = head_reg;
        fill_next     = fill_reg;
        off_next      = off_reg;
        cmd_next      = cmd_reg;
        len_next      = len_reg;
        xor_next      = xor_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_cmd_next    = m_cmd_reg;
        m_len_next    = m_len_reg;
        m_idx_next    = m_idx_reg;
        m_byte_next   = m_byte_reg;
        m_last_next   = m_last_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rd_off        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    wr_en = 1'b1;
                    if (full) begin
                        head_next = ptr_add(head_reg, CNT_W'(1));
                    end else begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
            end
            ST_ALIGN_RD: begin
                rd_en = 1'b1;
            end
            ST_ALIGN: begin
                if (fill_reg != '0 && rd_data != START_MARK) begin
                    head_next = ptr_add(head_reg, CNT_W'(1));
                    fill_next = fill_reg - CNT_W'(1);
                    rd_en     = 1'b1;
                    rd_off    = CNT_W'(1);
                end else if (fill_reg != '0 && fill_ext >= CMP_W'(HEADER_BYTES)) begin
                    rd_en  = 1'b1;
                    rd_off = CNT_W'(1);
                end
            end
            ST_CMD: begin
                cmd_next = rd_data;
                xor_next = START_MARK ^ rd_data;
                rd_en    = 1'b1;
                rd_off   = CNT_W'(2);
            end
            ST_LEN: begin
                len_next = rd_data[5:0];
                xor_next = xor_after;
                off_next = CNT_W'(HEADER_BYTES);
                rd_en    = 1'b1;
                rd_off   = CNT_W'(HEADER_BYTES);
            end
            ST_SUM: begin
                xor_next = xor_after;
                rd_en    = 1'b1;
                if (sum_done) begin
                    off_next = CNT_W'(HEADER_BYTES);
                    rd_off   = CNT_W'(HEADER_BYTES);
                end else begin
                    off_next = off_reg + CNT_W'(1);
                    rd_off   = off_reg + CNT_W'(1);
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = (xor_reg != '0) ? STAT_ERROR : STAT_EMPTY;
                    m_cmd_next    = cmd_reg;
                    m_len_next    = len_reg;
                    m_idx_next    = '0;
                    m_byte_next   = '0;
                    m_last_next   = 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_DATA;
                    m_cmd_next    = cmd_reg;
                    m_len_next    = len_reg;
                    m_idx_next    = idx_ext[5:0];
                    m_byte_next   = rd_data;
                    m_last_next   = emit_last;
                    if (!emit_last) begin
                        off_next = off_reg + CNT_W'(1);
                        rd_en    = 1'b1;
                        rd_off   = off_reg + CNT_W'(1);
                    end
                end
            end
            ST_DROP: begin
                head_next = ptr_add(head_reg, drop_ext[CNT_W-1:0]);
                fill_next = fill_reg - drop_ext[CNT_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
        off_reg      <= off_next;
        cmd_reg      <= cmd_next;
        len_reg      <= len_next;
        xor_reg      <= xor_next;
        m_status_reg <= m_status_next;
        m_cmd_reg    <= m_cmd_next;
        m_len_reg    <= m_len_next;
        m_idx_reg    <= m_idx_next;
        m_byte_reg   <= m_byte_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(TDATA_W - 28){1'b0}}, m_byte_reg, m_idx_reg, m_len_reg, m_cmd_reg};

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= BUFFER_BYTES[CNT_W-1:0])
        else $error("fill count beyond buffer size");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new transaction taken before locate pass");

    a_single_result_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STAT_DATA) |-> m_tlast)
        else $error("status or error result without last");

    a_fill_shrinks_only_on_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_ALIGN && state_reg != ST_DROP) |=> fill_reg >= $past(fill_reg))
        else $error("bytes lost outside alignment or frame removal");

endmodule
